@@ rtl/pgid_pkg.sv @@
// Package for the page id allocator: id type, operation and status codes,
// request/response payloads and RAM port structs. No dependencies.
package pgid_pkg;

    localparam int ID_BITS  = 10;
    localparam int ID_SPACE = 1 << ID_BITS;

    typedef logic [ID_BITS-1:0] t_id;

    localparam t_id INVALID_ID = '1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_REJECTED  = 2'd2
    } t_status;

    typedef struct packed {
        t_op operation;
        t_id page_id;
    } t_req;

    typedef struct packed {
        t_status     status;
        t_id         granted_id;
        logic        is_allocated;
        t_id         current_count;
        t_id         peak_count;
        t_id         free_count;
        logic [31:0] total_allocs;
        logic [31:0] total_frees;
    } t_rsp;

    typedef struct packed {
        logic we;
        t_id  waddr;
        t_id  wdata;
        logic re;
        t_id  raddr;
    } t_stk_req;

    typedef struct packed {
        logic we;
        t_id  waddr;
        logic wbit;
        logic re;
        t_id  raddr;
    } t_mark_req;

endpackage

@@ rtl/pgid_stack.sv @@
// Free stack RAM: one write and one registered read per cycle, with
// write-to-read bypass for a same-edge collision. Depends on pgid_pkg.
module pgid_stack (
    input  logic               i_clk,
    input  pgid_pkg::t_stk_req i_req,
    output pgid_pkg::t_id      o_rdata
);
    import pgid_pkg::*;

    t_id  r_mem [ID_SPACE];
    t_id  r_rdata;
    logic r_fwd_hit;
    t_id  r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata    <= r_mem[i_req.raddr];
            r_fwd_hit  <= i_req.we && (i_req.waddr == i_req.raddr);
            r_fwd_data <= i_req.wdata;
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

@@ rtl/pgid_mark.sv @@
// Freed-mark RAM, one bit per id: one write and one registered read per
// cycle, with write-to-read bypass. Depends on pgid_pkg.
module pgid_mark (
    input  logic                i_clk,
    input  pgid_pkg::t_mark_req i_req,
    output logic                o_rbit
);
    import pgid_pkg::*;

    logic r_mem [ID_SPACE];
    logic r_rbit;
    logic r_fwd_hit;
    logic r_fwd_bit;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wbit;
        end
        if (i_req.re) begin
            r_rbit    <= r_mem[i_req.raddr];
            r_fwd_hit <= i_req.we && (i_req.waddr == i_req.raddr);
            r_fwd_bit <= i_req.wbit;
        end
    end

    assign o_rbit = r_fwd_hit ? r_fwd_bit : r_rbit;

endmodule

@@ rtl/pgid_ctrl.sv @@
// Allocator state and decision logic: counters, bump pointer, stack depth,
// RAM write/read requests and the response. Depends on pgid_pkg.
module pgid_ctrl #(
    parameter int MAX_ID       = 1022,
    parameter int RESERVED_IDS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  pgid_pkg::t_req      i_req,
    input  pgid_pkg::t_id       i_stk_rdata,
    input  logic                i_mark_rbit,
    input  logic                i_accept,
    input  pgid_pkg::t_id       i_new_id,
    output pgid_pkg::t_stk_req  o_stk_req,
    output pgid_pkg::t_mark_req o_mark_req,
    output pgid_pkg::t_rsp      o_rsp
);
    import pgid_pkg::*;

    localparam t_id RESERVED = t_id'(RESERVED_IDS);
    localparam t_id LAST_ID  = t_id'(MAX_ID);

    t_id         r_depth, n_depth;
    t_id         r_next_fresh, n_next_fresh;
    t_id         r_live, n_live;
    t_id         r_peak, n_peak;
    logic [31:0] r_allocs, n_allocs;
    logic [31:0] r_frees, n_frees;

    t_status status;
    t_id     granted;
    logic    answer;
    logic    grant;
    logic    stk_we;
    logic    mark_we;
    t_id     mark_waddr;
    logic    mark_wbit;
    logic    reject;

    always_comb begin
        n_depth      = r_depth;
        n_next_fresh = r_next_fresh;
        n_live       = r_live;
        n_peak       = r_peak;
        n_allocs     = r_allocs;
        n_frees      = r_frees;
        status       = ST_OK;
        granted      = INVALID_ID;
        answer       = 1'b0;
        grant        = 1'b0;
        stk_we       = 1'b0;
        mark_we      = 1'b0;
        mark_waddr   = i_req.page_id;
        mark_wbit    = 1'b0;
        reject       = (i_req.page_id == INVALID_ID) || (i_req.page_id < RESERVED) ||
                       (i_req.page_id >= r_next_fresh) || i_mark_rbit;

        unique case (i_req.operation)
            OP_ALLOC: begin
                if (r_depth != '0) begin
                    n_depth    = r_depth - 1'b1;
                    granted    = i_stk_rdata;
                    mark_we    = 1'b1;
                    mark_waddr = i_stk_rdata;
                    grant      = 1'b1;
                end else if (r_next_fresh > LAST_ID) begin
                    status = ST_EXHAUSTED;
                end else begin
                    granted      = r_next_fresh;
                    n_next_fresh = r_next_fresh + 1'b1;
                    mark_we      = 1'b1;
                    mark_waddr   = r_next_fresh;
                    grant        = 1'b1;
                end
            end
            OP_FREE: begin
                if (reject) begin
                    status = ST_REJECTED;
                end else begin
                    stk_we    = 1'b1;
                    n_depth   = r_depth + 1'b1;
                    mark_we   = 1'b1;
                    mark_wbit = 1'b1;
                    n_frees   = r_frees + 32'd1;
                    n_live    = r_live - 1'b1;
                end
            end
            OP_QUERY: begin
                answer = (i_req.page_id != INVALID_ID) && (i_req.page_id < r_next_fresh) &&
                         ((i_req.page_id < RESERVED) || !i_mark_rbit);
            end
            OP_CLEAR: begin
                n_depth      = '0;
                n_next_fresh = RESERVED;
                n_live       = '0;
                n_peak       = '0;
                n_allocs     = '0;
                n_frees      = '0;
            end
        endcase

        if (grant) begin
            n_allocs = r_allocs + 32'd1;
            n_live   = r_live + 1'b1;
            n_peak   = (n_live > r_peak) ? n_live : r_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_next_fresh <= RESERVED;
            r_live       <= '0;
            r_peak       <= '0;
            r_allocs     <= '0;
            r_frees      <= '0;
        end else if (i_commit) begin
            r_depth      <= n_depth;
            r_next_fresh <= n_next_fresh;
            r_live       <= n_live;
            r_peak       <= n_peak;
            r_allocs     <= n_allocs;
            r_frees      <= n_frees;
        end
    end

    // read for the next transaction sees the state this one leaves
    always_comb begin
        o_stk_req.we     = stk_we && i_commit;
        o_stk_req.waddr  = r_depth;
        o_stk_req.wdata  = i_req.page_id;
        o_stk_req.re     = i_accept;
        o_stk_req.raddr  = (i_commit ? n_depth : r_depth) - 1'b1;

        o_mark_req.we    = mark_we && i_commit;
        o_mark_req.waddr = mark_waddr;
        o_mark_req.wbit  = mark_wbit;
        o_mark_req.re    = i_accept;
        o_mark_req.raddr = i_new_id;
    end

    always_comb begin
        o_rsp.status        = status;
        o_rsp.granted_id    = granted;
        o_rsp.is_allocated  = answer;
        o_rsp.current_count = n_live;
        o_rsp.peak_count    = n_peak;
        o_rsp.free_count    = n_depth;
        o_rsp.total_allocs  = n_allocs;
        o_rsp.total_frees   = n_frees;
    end

    a_id_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_live} + {1'b0, r_depth} + {1'b0, RESERVED}) == {1'b0, r_next_fresh})
        else $error("live ids plus stacked ids do not match issued ids");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_live)
        else $error("peak count below current count");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_next_fresh} <= ({1'b0, LAST_ID} + 1'b1))
        else $error("bump pointer past last id plus one");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && i_req.operation == OP_ALLOC && r_depth != '0) |=>
        (r_depth == $past(r_depth) - 1'b1))
        else $error("pop did not shrink the free stack");

endmodule

@@ rtl/page_id_allocator_top.sv @@
// Top level of the page id allocator: input stage, result register and
// handshakes. Uses pgid_pkg, pgid_ctrl, pgid_stack and pgid_mark.
//
//   Channel | Direction | Handshake                  | Payload
//   request | in        | i_in_valid / o_in_ready    | i_in_data  (t_req)
//   result  | out       | o_out_valid / i_out_ready  | o_out_data (t_rsp)
//
// Throughput is one transaction per cycle unless the result stalls; a request
// waits in the input stage, its result in the result register. The accepting
// edge issues the registered reads of the free stack and mark RAMs, the commit
// edge updates state and the result. Reset is synchronous and clears control
// state only; RAMs are not swept, as no unwritten entry is used. A stalled
// result holds while one more request is taken into the input stage.
module page_id_allocator_top #(
    parameter int MAX_ID       = 1022,
    parameter int RESERVED_IDS = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pgid_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pgid_pkg::t_rsp o_out_data
);
    import pgid_pkg::*;

    logic      r_s1_valid;
    t_req      r_s1_req;
    logic      r_out_valid;
    t_rsp      r_out_data;

    logic      w_commit;
    logic      w_accept;
    t_id       w_stk_rdata;
    logic      w_mark_rbit;
    t_stk_req  w_stk_req;
    t_mark_req w_mark_req;
    t_rsp      w_rsp;

    assign w_commit   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_commit;
    assign w_accept   = i_in_valid && o_in_ready;

    pgid_ctrl #(
        .MAX_ID       (MAX_ID),
        .RESERVED_IDS (RESERVED_IDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (w_commit),
        .i_req       (r_s1_req),
        .i_stk_rdata (w_stk_rdata),
        .i_mark_rbit (w_mark_rbit),
        .i_accept    (w_accept),
        .i_new_id    (i_in_data.page_id),
        .o_stk_req   (w_stk_req),
        .o_mark_req  (w_mark_req),
        .o_rsp       (w_rsp)
    );

    pgid_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (w_stk_req),
        .o_rdata (w_stk_rdata)
    );

    pgid_mark u_mark (
        .i_clk  (i_clk),
        .i_req  (w_mark_req),
        .o_rbit (w_mark_rbit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_commit) begin
                r_s1_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req <= i_in_data;
        end
        if (w_commit) begin
            r_out_data <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid)
        else $error("committed transaction did not reach the result register");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_commit) |=> (r_s1_valid && $stable(r_s1_req)))
        else $error("stalled input stage lost its transaction");

    a_no_commit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid) |-> !w_commit)
        else $error("commit with empty input stage");

endmodule
